// ----- rtl/tql_pkg.sv -----
// ----------------------------------------------------------------------------
// tql_pkg
// Shared widths, register indexes, reset values and the command and status
// bundles between the controller and the datapath of the Q-learning engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tql_pkg;

    localparam int VAL_W      = 16;
    localparam int STATE_W    = 7;
    localparam int MOVE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE    = 2'd2;

    localparam logic [VAL_W-1:0] LEARN_RATE_RST = 16'd6554;
    localparam logic [VAL_W-1:0] DISCOUNT_RST   = 16'd58982;
    localparam logic [VAL_W-1:0] EXPLORE_RST    = 16'd6554;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic scan_rd;
        logic q_rd;
        logic gmul;
        logic td;
        logic amul;
        logic upd;
        logic out_load;
    } tql_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic scan_last;
        logic is_learn;
        logic out_free;
    } tql_sts_t;

endpackage

`default_nettype wire

// ----- rtl/tql_controller.sv -----
// ----------------------------------------------------------------------------
// tql_controller
// Sequencer for the Q-learning engine: table clear after reset, row scan,
// target read, update arithmetic and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tql_controller
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output tql_pkg::tql_cmd_t  cmd,
    input  tql_pkg::tql_sts_t  sts
);

    import tql_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_SCAN  = 9'b000000100,
        ST_QRD   = 9'b000001000,
        ST_GMUL  = 9'b000010000,
        ST_TD    = 9'b000100000,
        ST_AMUL  = 9'b001000000,
        ST_UPD   = 9'b010000000,
        ST_DONE  = 9'b100000000
    } tql_state_t;

    tql_state_t state_reg;
    tql_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_QRD;
                end
            end
            ST_QRD:
            begin
                cmd.q_rd   = 1'b1;
                state_next = sts.is_learn ? ST_GMUL : ST_DONE;
            end
            ST_GMUL:
            begin
                cmd.gmul   = 1'b1;
                state_next = ST_TD;
            end
            ST_TD:
            begin
                cmd.td     = 1'b1;
                state_next = ST_AMUL;
            end
            ST_AMUL:
            begin
                cmd.amul   = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/tql_datapath.sv -----
// ----------------------------------------------------------------------------
// tql_datapath
// Value table memory, configuration registers, row maximum search, the
// fixed-point learning update and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tql_datapath
#(
    parameter int NUM_STATES = 81,
    parameter int NUM_MOVES  = 5
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [tql_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tql_pkg::VAL_W-1:0]           cfg_data,
    input  logic [tql_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [tql_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tuser,
    input  tql_pkg::tql_cmd_t                   cmd,
    output tql_pkg::tql_sts_t                   sts
);

    import tql_pkg::*;

    localparam int DEPTH  = NUM_STATES * NUM_MOVES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(NUM_MOVES);
    localparam int RM_W   = MOVE_W + 1;

    // configuration
    logic [VAL_W-1:0] lr_reg;
    logic [VAL_W-1:0] disc_reg;
    logic [VAL_W-1:0] eps_reg;

    // item payload
    logic                      act_reg;
    logic [STATE_W-1:0]        s_reg;
    logic [MOVE_W-1:0]         a_reg;
    logic signed [VAL_W-1:0]   rew_reg;
    logic [STATE_W-1:0]        ns_reg;
    logic [VAL_W-1:0]          draw_reg;
    logic [MOVE_W-1:0]         rmove_reg;

    // memory and counters
    logic [VAL_W-1:0]          mem [DEPTH];
    logic [VAL_W-1:0]          rd_data_reg;
    logic [ADDR_W-1:0]         clr_cnt_reg;
    logic [CNT_W-1:0]          scan_cnt_reg;
    logic                      cmp_vld_reg;
    logic [CNT_W-1:0]          cmp_idx_reg;
    logic signed [VAL_W-1:0]   best_reg;
    logic [CNT_W-1:0]          best_idx_reg;

    // update arithmetic
    logic signed [VAL_W-1:0]   q_reg;
    logic signed [32:0]        prod_g_reg;
    logic signed [34:0]        td_reg;
    logic signed [34:0]        td_next;
    logic signed [51:0]        prod_a_reg;
    logic signed [VAL_W-1:0]   nv_reg;

    // output register
    logic                      m_valid_reg;
    logic [MOVE_W-1:0]         m_pick_reg;
    logic                      m_expl_reg;
    logic [VAL_W-1:0]          m_val_reg;

    logic [STATE_W-1:0]        scan_row;
    logic                      row_ok;
    logic                      t_ok;
    logic [31:0]               scan_addr_full;
    logic [31:0]               tgt_addr_full;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [VAL_W-1:0]          wr_data;
    logic signed [VAL_W-1:0]   scan_val;
    logic signed [16:0]        diff;
    logic signed [19:0]        step;
    logic signed [20:0]        nv_wide;
    logic signed [VAL_W-1:0]   sat_val;
    logic [RM_W-1:0]           rm_mod;
    logic                      explore;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg   <= LEARN_RATE_RST;
            disc_reg <= DISCOUNT_RST;
            eps_reg  <= EXPLORE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LEARN_RATE: lr_reg   <= cfg_data;
                CFG_DISCOUNT:   disc_reg <= cfg_data;
                CFG_EXPLORE:    eps_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg   <= s_tuser;
            s_reg     <= s_tdata[6:0];
            a_reg     <= s_tdata[9:7];
            rew_reg   <= s_tdata[25:10];
            ns_reg    <= s_tdata[32:26];
            draw_reg  <= s_tdata[48:33];
            rmove_reg <= s_tdata[51:49];
        end
    end

    assign scan_row       = act_reg ? ns_reg : s_reg;
    assign row_ok         = (32'(scan_row) < 32'(NUM_STATES));
    assign t_ok           = (32'(s_reg) < 32'(NUM_STATES)) && (32'(a_reg) < 32'(NUM_MOVES));
    assign scan_addr_full = 32'(scan_row) * 32'(NUM_MOVES) + 32'(scan_cnt_reg);
    assign tgt_addr_full  = 32'(s_reg) * 32'(NUM_MOVES) + 32'(a_reg);
    assign rd_addr        = cmd.q_rd ? tgt_addr_full[ADDR_W-1:0] : scan_addr_full[ADDR_W-1:0];
    assign wr_en          = cmd.clr_wr || (cmd.upd && t_ok);
    assign wr_addr        = cmd.clr_wr ? clr_cnt_reg : tgt_addr_full[ADDR_W-1:0];
    assign wr_data        = cmd.clr_wr ? '0 : sat_val;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            scan_cnt_reg <= '0;
            cmp_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.load)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan_rd)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            cmp_vld_reg <= cmd.scan_rd;
        end
    end

    // rows outside the table read as zero
    assign scan_val = row_ok ? $signed(rd_data_reg) : '0;

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= scan_cnt_reg;
        if (cmp_vld_reg)
        begin
            if ((cmp_idx_reg == '0) || (scan_val > best_reg))
            begin
                best_reg     <= scan_val;
                best_idx_reg <= cmp_idx_reg;
            end
        end
    end

    assign diff    = {rew_reg[VAL_W-1], rew_reg} - {q_reg[VAL_W-1], q_reg};
    assign td_next = {{2{diff[16]}}, diff, 16'b0} + {{2{prod_g_reg[32]}}, prod_g_reg};
    assign step    = prod_a_reg[51:32];
    assign nv_wide = {{5{q_reg[VAL_W-1]}}, q_reg} + {step[19], step};

    always_comb
    begin
        if (!nv_wide[20] && (nv_wide[19:15] != 5'h00))
        begin
            sat_val = 16'sh7fff;
        end
        else if (nv_wide[20] && (nv_wide[19:15] != 5'h1f))
        begin
            sat_val = 16'sh8000;
        end
        else
        begin
            sat_val = nv_wide[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gmul)
        begin
            q_reg      <= t_ok ? $signed(rd_data_reg) : '0;
            prod_g_reg <= 33'($signed({1'b0, disc_reg})) * 33'(best_reg);
        end
        if (cmd.td)
        begin
            td_reg <= td_next;
        end
        if (cmd.amul)
        begin
            prod_a_reg <= 52'(td_reg) * 52'($signed({1'b0, lr_reg}));
        end
        if (cmd.upd)
        begin
            nv_reg <= t_ok ? sat_val : '0;
        end
    end

    always_comb
    begin
        rm_mod = {1'b0, rmove_reg};
        for (int i = 0; i < 4; i++)
        begin
            if (rm_mod >= RM_W'(NUM_MOVES))
            begin
                rm_mod = rm_mod - RM_W'(NUM_MOVES);
            end
        end
    end

    assign explore = (draw_reg < eps_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (act_reg)
            begin
                m_pick_reg <= a_reg;
                m_expl_reg <= 1'b0;
                m_val_reg  <= nv_reg;
            end
            else
            begin
                m_pick_reg <= explore ? MOVE_W'(rm_mod) : MOVE_W'(best_idx_reg);
                m_expl_reg <= explore;
                m_val_reg  <= best_reg;
            end
        end
    end

    assign m_tvalid      = m_valid_reg;
    assign m_tdata       = {5'b0, m_val_reg, m_pick_reg};
    assign m_tuser       = m_expl_reg;

    assign sts.clr_last  = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign sts.scan_last = (scan_cnt_reg == CNT_W'(NUM_MOVES - 1));
    assign sts.is_learn  = act_reg;
    assign sts.out_free  = !m_valid_reg || m_tready;

endmodule

`default_nettype wire

// ----- rtl/tabular_q_learning_engine.sv -----
// ----------------------------------------------------------------------------
// tabular_q_learning_engine
// Tabular Q-learning with epsilon-greedy move choice on a signed Q8.8
// value table.
// ----------------------------------------------------------------------------
//  channel  | signals                              | transfer
//  ---------+--------------------------------------+-------------------------
//  s_axis   | s_tvalid s_tready s_tdata s_tuser    | one choose or learn item
//  m_axis   | m_tvalid m_tready m_tdata m_tuser    | one result per item
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data| one register write
//
//  The engine takes the next item only once the previous one has been handed
//  to the output register; the row scan reads one word per cycle through the
//  single read port of the value table. After reset a clearing pass zeroes
//  the table, with s_tready low.
//  A finished result waits in the output register while the next item is
//  taken; a stalled m_axis holds the engine before the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tabular_q_learning_engine
#(
    parameter int NUM_STATES = 81,
    parameter int NUM_MOVES  = 5
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // state_index[6:0] move_index[9:7] reward[25:10] next_state[32:26]
    // random_draw[48:33] random_move[51:49], zero pad to 56
    input  logic [tql_pkg::IN_DATA_W-1:0]      s_tdata,
    // action
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // picked_move[2:0] value_out[18:3], zero pad to 24
    output logic [tql_pkg::OUT_DATA_W-1:0]     m_tdata,
    // explored
    output logic                               m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tql_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tql_pkg::VAL_W-1:0]          cfg_data
);

    import tql_pkg::*;

    tql_cmd_t cmd;
    tql_sts_t sts;

    assign cfg_ready = 1'b1;

    tql_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tql_datapath
    #(
        .NUM_STATES (NUM_STATES),
        .NUM_MOVES  (NUM_MOVES)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

`ifndef SYNTH
    a_no_input_during_clear : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> !s_tready)
        else $error("input ready while clearing value table");

    a_single_writer : assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_wr && cmd.upd))
        else $error("clear and update write collide");

    a_no_result_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over pending result");

    a_busy_after_transfer : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item taken while first in progress");
`endif

endmodule

`default_nettype wire

// ----- tb/q_table_scoreboard_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q_table_scoreboard_pkg
// Item and result types for the Q-learning engine bench, and a scoreboard
// that keeps its own copy of the value table and the three registers. It
// predicts each result as an item transfers, then checks results in order.
// ----------------------------------------------------------------------------

package q_table_scoreboard_pkg;

    import tql_pkg::*;

    localparam int ROWS  = 81;
    localparam int MOVES = 5;

    typedef struct packed {
        logic                      learn;
        logic [STATE_W-1:0]        state;
        logic [MOVE_W-1:0]         move;
        logic signed [VAL_W-1:0]   reward;
        logic [STATE_W-1:0]        next;
        logic [VAL_W-1:0]          draw;
        logic [MOVE_W-1:0]         rand_move;
    } q_item_t;

    typedef struct packed {
        logic [MOVE_W-1:0]         move;
        logic                      explored;
        logic signed [VAL_W-1:0]   value;
    } q_result_t;

    class q_table_scoreboard;

        logic signed [VAL_W-1:0] q_table [ROWS*MOVES];
        logic [VAL_W-1:0]        alpha;
        logic [VAL_W-1:0]        gamma;
        logic [VAL_W-1:0]        epsilon;
        q_result_t               awaited_results [$];
        int                      mismatches;
        int                      checked;
        int                      learns;
        int                      chooses;
        int                      explores;

        function new();
            foreach (q_table[k])
            begin
                q_table[k] = '0;
            end
            alpha      = LEARN_RATE_RST;
            gamma      = DISCOUNT_RST;
            epsilon    = EXPLORE_RST;
            mismatches = 0;
            checked    = 0;
            learns     = 0;
            chooses    = 0;
            explores   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [VAL_W-1:0] data);
            case (index)
                CFG_LEARN_RATE: alpha   = data;
                CFG_DISCOUNT:   gamma   = data;
                CFG_EXPLORE:    epsilon = data;
                default:        ;
            endcase
        endfunction

        function void best_in_row(int unsigned row, output logic signed [VAL_W-1:0] best,
                                  output int unsigned best_move);
            best      = '0;
            best_move = 0;
            if (row < ROWS)
            begin
                best = q_table[row*MOVES];
                for (int m = 1; m < MOVES; m++)
                begin
                    if (q_table[row*MOVES+m] > best)
                    begin
                        best      = q_table[row*MOVES+m];
                        best_move = m;
                    end
                end
            end
        endfunction

        function void note_item(q_item_t it);
            q_result_t               res;
            logic signed [VAL_W-1:0] best;
            int unsigned             best_move;
            int unsigned             k;
            longint                  q;
            longint                  td;
            longint                  nv;
            res = '0;
            if (!it.learn)
            begin
                chooses++;
                best_in_row(it.state, best, best_move);
                res.value = best;
                if (it.draw < epsilon)
                begin
                    res.move     = MOVE_W'(it.rand_move % MOVES);
                    res.explored = 1'b1;
                    explores++;
                end
                else
                begin
                    res.move = MOVE_W'(best_move);
                end
            end
            else
            begin
                learns++;
                res.move = it.move;
                best_in_row(it.next, best, best_move);
                if (it.state < ROWS && it.move < MOVES)
                begin
                    k  = it.state * MOVES + it.move;
                    q  = longint'(q_table[k]);
                    td = (longint'($signed(it.reward)) <<< 16)
                       + longint'(gamma) * longint'(best) - (q <<< 16);
                    nv = q + ((td * longint'(alpha)) >>> 32);
                    if (nv > 32767)
                        nv = 32767;
                    if (nv < -32768)
                        nv = -32768;
                    q_table[k] = nv[VAL_W-1:0];
                    res.value  = nv[VAL_W-1:0];
                end
            end
            awaited_results.push_back(res);
        endfunction

        function void check_result(q_result_t got);
            q_result_t want;
            checked++;
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d: move %0d explored %0d value %0d",
                             checked, got.move, got.explored, $signed(got.value));
                return;
            end
            want = awaited_results.pop_front();
            if (got.move !== want.move || got.explored !== want.explored
                || got.value !== want.value)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected move %0d explored %0d value %0d, %s %0d %0d %0d",
                             checked, want.move, want.explored, $signed(want.value),
                             "got", got.move, got.explored, $signed(got.value));
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

    endclass

endpackage

// ----- tb/tabular_q_learning_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tabular_q_learning_engine_tb
// Drives choose and learn items into the Q-learning engine, first a directed
// set of edge cases and then random runs under several register settings
// and back-pressure mixes, and checks every result against the scoreboard.
// ----------------------------------------------------------------------------

module tabular_q_learning_engine_tb;

    import tql_pkg::*;
    import q_table_scoreboard_pkg::*;

    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 16;
    localparam int BLOCK_ITEMS   = 142;
    localparam int NUM_BLOCKS    = 6;
    localparam int TIMEOUT_NS    = 2000000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [VAL_W-1:0]      cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_ready;

    int                    send_idle = 0;
    int                    recv_idle = 0;
    int                    settings  = 0;
    q_table_scoreboard     q_board;

    always #2 clk = ~clk;

    tabular_q_learning_engine
    #(
        .NUM_STATES (ROWS),
        .NUM_MOVES  (MOVES)
    )
    i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic q_item_t make_item(logic learn, logic [STATE_W-1:0] state,
                                          logic [MOVE_W-1:0] move, logic [VAL_W-1:0] reward,
                                          logic [STATE_W-1:0] next, logic [VAL_W-1:0] draw,
                                          logic [MOVE_W-1:0] rand_move);
        q_item_t it;
        it.learn     = learn;
        it.state     = state;
        it.move      = move;
        it.reward    = reward;
        it.next      = next;
        it.draw      = draw;
        it.rand_move = rand_move;
        return it;
    endfunction

    function automatic logic [STATE_W-1:0] pick_state();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return STATE_W'($urandom_range(0, 7));
        else if (sel < 92)
            return STATE_W'($urandom_range(0, ROWS-1));
        return STATE_W'($urandom_range(ROWS, 127));
    endfunction

    function automatic q_item_t random_item(logic [VAL_W-1:0] eps);
        q_item_t it;
        int      sel;
        it.learn = 1'($urandom_range(0, 1));
        it.state = pick_state();
        it.next  = pick_state();
        it.move  = ($urandom_range(0, 9) == 0) ? MOVE_W'($urandom_range(MOVES, 7))
                                                : MOVE_W'($urandom_range(0, MOVES-1));
        sel = $urandom_range(0, 99);
        if (sel < 30)
            it.reward = 16'($urandom);
        else if (sel < 50)
            it.reward = ($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h8000;
        else
            it.reward = 16'($urandom_range(0, 2047)) - 16'd1024;
        if ($urandom_range(0, 99) < 25)
            it.draw = eps + 16'($urandom_range(0, 4)) - 16'd2;
        else
            it.draw = 16'($urandom);
        it.rand_move = MOVE_W'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic send_item(q_item_t it);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.learn;
        s_tdata  <= {{(IN_DATA_W-52){1'b0}}, it.rand_move, it.draw, it.next,
                     it.reward, it.move, it.state};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        q_board.note_item(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [VAL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        q_board.write_reg(index, data);
    endtask

    task automatic apply_setting(logic [VAL_W-1:0] alpha, logic [VAL_W-1:0] gamma,
                                 logic [VAL_W-1:0] eps, logic poke_unused);
        write_reg(CFG_LEARN_RATE, alpha);
        write_reg(CFG_DISCOUNT, gamma);
        write_reg(CFG_EXPLORE, eps);
        if (poke_unused)
            write_reg(CFG_UNUSED, 16'h5A5A);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        while (q_board.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        q_result_t got;
        forever
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.move     = m_tdata[2:0];
                got.explored = m_tuser;
                got.value    = m_tdata[18:3];
                q_board.check_result(got);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [VAL_W-1:0] alpha_set [NUM_BLOCKS];
        logic [VAL_W-1:0] gamma_set [NUM_BLOCKS];
        logic [VAL_W-1:0] eps_set   [NUM_BLOCKS];
        alpha_set = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h8000, 16'h0001, LEARN_RATE_RST};
        gamma_set = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h0000, 16'hFFFF, DISCOUNT_RST};
        eps_set   = '{16'h0000, 16'hFFFF, 16'($urandom), 16'h4000, 16'hFFFF, EXPLORE_RST};
        q_board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        send_item(make_item(1'b0, 7'd0, 3'd0, 16'h0000, 7'd0, 16'hFFFF, 3'd0));
        send_item(make_item(1'b0, 7'd0, 3'd0, 16'h0000, 7'd0, 16'h0000, 3'd7));
        send_item(make_item(1'b0, 7'd0, 3'd0, 16'h0000, 7'd0, 16'd6553, 3'd5));
        send_item(make_item(1'b0, 7'd0, 3'd0, 16'h0000, 7'd0, 16'd6554, 3'd6));
        send_item(make_item(1'b1, 7'd0, 3'd1, 16'h7FFF, 7'd0, 16'hFFFF, 3'd7));
        send_item(make_item(1'b1, 7'd0, 3'd3, 16'h7FFF, 7'd0, 16'hFFFF, 3'd7));
        send_item(make_item(1'b1, 7'd0, 3'd4, 16'h7FFF, 7'd0, 16'hFFFF, 3'd7));
        send_item(make_item(1'b0, 7'd0, 3'd0, 16'h0000, 7'd0, 16'hFFFF, 3'd0));
        send_item(make_item(1'b1, 7'd80, 3'd4, 16'h8000, 7'd80, 16'h0000, 3'd0));
        send_item(make_item(1'b1, 7'd80, 3'd0, 16'h8000, 7'd127, 16'h0000, 3'd0));
        send_item(make_item(1'b0, 7'd80, 3'd0, 16'h0000, 7'd0, 16'hFFFF, 3'd0));
        send_item(make_item(1'b0, 7'd127, 3'd0, 16'h0000, 7'd0, 16'hFFFF, 3'd0));
        send_item(make_item(1'b0, 7'd81, 3'd0, 16'h0000, 7'd0, 16'h0000, 3'd4));
        send_item(make_item(1'b1, 7'd81, 3'd0, 16'd1000, 7'd0, 16'h0000, 3'd0));
        send_item(make_item(1'b1, 7'd5, 3'd5, 16'd1000, 7'd0, 16'h0000, 3'd0));
        send_item(make_item(1'b1, 7'd5, 3'd7, 16'hFC18, 7'd0, 16'h0000, 3'd0));
        send_item(make_item(1'b1, 7'd1, 3'd2, 16'h0000, 7'd0, 16'h0000, 3'd0));
        send_item(make_item(1'b1, 7'd2, 3'd0, 16'h0001, 7'd81, 16'h0000, 3'd0));
        send_item(make_item(1'b0, 7'd1, 3'd0, 16'h0000, 7'd0, 16'hFFFF, 3'd0));
        send_item(make_item(1'b1, 7'd3, 3'd1, 16'd256, 7'd127, 16'h0000, 3'd0));
        send_item(make_item(1'b1, 7'd3, 3'd3, 16'd256, 7'd127, 16'h0000, 3'd0));
        send_item(make_item(1'b0, 7'd3, 3'd0, 16'h0000, 7'd0, 16'hFFFF, 3'd0));
        send_item(make_item(1'b1, 7'd4, 3'd0, 16'hFF00, 7'd127, 16'h0000, 3'd0));
        send_item(make_item(1'b0, 7'd4, 3'd0, 16'h0000, 7'd0, 16'hFFFF, 3'd0));
        send_item(make_item(1'b0, 7'd4, 3'd0, 16'h0000, 7'd0, 16'h0000, 3'd3));
        s_tvalid <= 1'b0;
        drain();

        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            apply_setting(alpha_set[b], gamma_set[b], eps_set[b], b == 0);
            if (b < 2)
            begin
                send_idle = 19;
                recv_idle = 74;
            end
            else if (b < 4)
            begin
                send_idle = 74;
                recv_idle = 19;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            repeat (BLOCK_ITEMS) send_item(random_item(eps_set[b]));
            s_tvalid <= 1'b0;
            drain();
        end

        if (q_board.pending() != 0)
        begin
            $display("%0d expected results never arrived", q_board.pending());
            q_board.mismatches += q_board.pending();
        end
        $display("ran %0d learn and %0d choose items (%0d explored) over %0d register settings",
                 q_board.learns, q_board.chooses, q_board.explores, settings + 1);
        $display("checked %0d results, %0d failures", q_board.checked, q_board.mismatches);
        if (q_board.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/tql_pkg.sv
rtl/tql_controller.sv
rtl/tql_datapath.sv
rtl/tabular_q_learning_engine.sv
tb/q_table_scoreboard_pkg.sv
tb/tabular_q_learning_engine_tb.sv
